// ===== src/emtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package emtr_pkg;
	localparam int TableEntriesDef = 16;
	localparam int SuspendDepthDef = 10;

	typedef enum logic [1:0] {
		MODE_WAITING  = 2'd0,
		MODE_DECIDING = 2'd1,
		MODE_TAPPING  = 2'd2,
		MODE_HOLDING  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_KEY   = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_REG   = 2'd0,
		KIND_UNREG = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_EARLY = 2'd0,
		REG_LATE  = 2'd1,
		REG_RULE2 = 2'd2,
		REG_USE   = 2'd3
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_DECIDE,
		ST_LIST,
		ST_LIST_WAIT,
		ST_LIST_EMIT,
		ST_SINGLE_RD,
		ST_SINGLE_EMIT,
		ST_END
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic scan_start;
		logic scan_step;
		logic list_start;
		logic list_step;
		logic list_hold;
		logic single_tap;
		logic rd_single;
		logic emit_list;
		logic emit_single;
		logic single_unreg;
		logic emit_end;
		logic set_mode;
		mode_t new_mode;
		logic set_dstamp;
		logic set_tstamp;
		logic push_susp;
		logic clr_susp;
		logic set_held_cnt;
		logic unhold;
		logic write_entry;
		logic set_pass;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic hit;
		logic list_done;
		logic out_busy;
		mode_t mode;
		action_t action;
		logic pressed;
		logic held_bit;
		logic held_cnt_le1;
		logic early_hit;
		logic late_hit_d;
		logic late_hit_t;
		logic rule_two;
	} stat_t;
endpackage
`default_nettype wire

// ===== src/emtr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module emtr_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/emtr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module emtr_ctrl import emtr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire stat_t st,
	output cmd_t       cmd
);
	state_t state_q, state_d;
	// what follows the suspend list emission
	logic   after_unreg_q, after_unreg_d;
	logic   after_hold_q, after_hold_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			after_unreg_q <= 1'b0;
			after_hold_q  <= 1'b0;
		end else begin
			state_q       <= state_d;
			after_unreg_q <= after_unreg_d;
			after_hold_q  <= after_hold_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		after_unreg_d = after_unreg_q;
		after_hold_d  = after_hold_q;
		cmd           = '0;
		cmd.new_mode  = MODE_WAITING;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in    = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority case (st.action)
					ACT_KEY: begin
						if (st.scan_done) begin
							state_d = ST_DECIDE;
						end else begin
							cmd.scan_step = 1'b1;
							state_d       = ST_SCAN_WAIT;
						end
					end
					ACT_TICK: begin
						state_d = ST_END;
						if (st.mode == MODE_DECIDING && st.late_hit_d) begin
							cmd.list_start = 1'b1;
							cmd.list_hold  = 1'b1;
							cmd.set_held_cnt = 1'b1;
							after_hold_d   = 1'b1;
							after_unreg_d  = 1'b0;
							state_d        = ST_LIST;
						end else if (st.mode == MODE_TAPPING && st.late_hit_t) begin
							cmd.set_mode = 1'b1;
							cmd.new_mode = MODE_WAITING;
						end
					end
					ACT_WRITE: begin
						cmd.write_entry = 1'b1;
						state_d         = ST_END;
					end
					default: state_d = ST_END;
				endcase
			end
			ST_SCAN_WAIT: begin
				// registered read of the table: compare lands in the next cycle
				state_d = st.hit ? ST_DECIDE : ST_SCAN;
			end
			ST_DECIDE: begin
				state_d = ST_END;
				cmd.set_pass = 1'b1;
				after_unreg_d = 1'b0;
				after_hold_d  = 1'b0;
				unique case (st.mode)
					MODE_WAITING: begin
						if (st.pressed) begin
							if (st.hit) begin
								cmd.push_susp  = 1'b1;
								cmd.set_dstamp = 1'b1;
								cmd.set_mode   = 1'b1;
								cmd.new_mode   = MODE_DECIDING;
							end else if (st.rule_two) begin
								cmd.list_start = 1'b1;
								state_d        = ST_LIST;
							end
						end
					end
					MODE_DECIDING: begin
						if (st.hit) begin
							if (st.pressed) begin
								cmd.push_susp = 1'b1;
								if (st.early_hit) begin
									cmd.list_start = 1'b1;
									state_d        = ST_LIST;
								end
							end else begin
								cmd.list_start = 1'b1;
								after_unreg_d  = 1'b1;
								state_d        = ST_LIST;
							end
						end else if (st.pressed) begin
							cmd.list_start = 1'b1;
							state_d        = ST_LIST;
						end
					end
					MODE_TAPPING: begin
						if (st.hit) begin
							cmd.single_tap = 1'b1;
							cmd.rd_single  = 1'b1;
							if (st.pressed) begin
								cmd.set_tstamp = 1'b1;
							end else begin
								cmd.single_unreg = 1'b1;
							end
							state_d = ST_SINGLE_RD;
						end else if (st.pressed) begin
							cmd.set_tstamp = 1'b1;
						end
					end
					default: begin
						if (st.hit) begin
							cmd.rd_single = 1'b1;
							if (st.pressed) begin
								cmd.single_tap = 1'b1;
								cmd.set_tstamp = 1'b1;
							end else if (st.held_bit) begin
								cmd.single_unreg = 1'b1;
								cmd.unhold       = 1'b1;
								if (st.held_cnt_le1) begin
									cmd.set_mode = 1'b1;
									cmd.new_mode = MODE_WAITING;
								end
							end else begin
								cmd.single_tap   = 1'b1;
								cmd.single_unreg = 1'b1;
							end
							state_d = ST_SINGLE_RD;
						end else if (st.pressed) begin
							cmd.set_tstamp = 1'b1;
						end
					end
				endcase
			end
			ST_LIST: begin
				if (st.list_done) begin
					cmd.clr_susp = 1'b1;
					cmd.set_mode = 1'b1;
					if (after_hold_q) begin
						cmd.new_mode = MODE_HOLDING;
						state_d      = ST_END;
					end else begin
						cmd.new_mode   = MODE_TAPPING;
						cmd.set_tstamp = 1'b1;
						if (after_unreg_q) begin
							cmd.single_tap   = 1'b1;
							cmd.single_unreg = 1'b1;
							cmd.rd_single    = 1'b1;
							state_d          = ST_SINGLE_RD;
						end else begin
							state_d = ST_END;
						end
					end
				end else begin
					cmd.list_step = 1'b1;
					state_d       = ST_LIST_WAIT;
				end
			end
			ST_LIST_WAIT: state_d = ST_LIST_EMIT;
			ST_LIST_EMIT: begin
				if (!st.out_busy) begin
					cmd.emit_list = 1'b1;
					state_d       = ST_LIST;
				end
			end
			ST_SINGLE_RD: state_d = ST_SINGLE_EMIT;
			ST_SINGLE_EMIT: begin
				if (!st.out_busy) begin
					cmd.emit_single = 1'b1;
					state_d         = ST_END;
				end
			end
			ST_END: begin
				if (!st.out_busy) begin
					cmd.emit_end = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_hold_not_unreg: assert property (@(posedge clk) disable iff (!arst_n)
		!(after_hold_q && after_unreg_q && state_q == ST_LIST))
		else $error("hold and unregister follow-ups both pending");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken while busy");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_end |=> state_q == ST_IDLE)
		else $error("end item not followed by idle");
endmodule
`default_nettype wire

// ===== src/emtr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module emtr_dp import emtr_pkg::*; #(
	parameter int TableEntries = TableEntriesDef,
	parameter int SuspendDepth = SuspendDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            st,
	input  wire logic [1:0]  action,
	input  wire logic        pressed,
	input  wire logic [15:0] key_code,
	input  wire logic [4:0]  active_layer,
	input  wire logic [15:0] now_ms,
	input  wire logic [3:0]  entry_index,
	input  wire logic [15:0] hold_code,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic      [1:0]  kind,
	output logic      [15:0] code,
	output logic             pass_through,
	output logic             last,
	output logic             out_valid,
	input  wire logic        out_stall
);
	localparam int IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int ScanW = $clog2(TableEntries + 1);
	localparam int SusW  = (SuspendDepth > 1) ? $clog2(SuspendDepth) : 1;
	localparam int CntW  = $clog2(SuspendDepth + 1);
	localparam int EntW  = 5 + 16 + 16;

	logic [15:0] early_q, late_q;
	logic        rule2_q;
	logic [4:0]  use_q;

	action_t     action_q;
	logic        pressed_q;
	logic [15:0] key_q, now_q, hold_in_q;
	logic [4:0]  layer_q;
	logic [3:0]  slot_q;

	mode_t       mode_q;
	logic [15:0] dstamp_q, tstamp_q;
	logic [CntW-1:0] scount_q, hcount_q;
	logic [CntW-1:0] sidx_q;
	logic [ScanW-1:0] scan_q;
	logic [ScanW-1:0] limit;
	logic [IdxW-1:0]  hit_id_q, rd_addr_q, ent_addr_q;
	logic            hit_q, pass_q;
	logic [TableEntries-1:0] held_q;

	logic [EntW-1:0] ent_rd;
	logic [IdxW-1:0] sus_rd;
	logic [IdxW-1:0] ent_raddr;
	logic [SusW-1:0] sus_raddr;
	logic            sus_we;
	logic            ent_we;

	logic        ov_q;
	logic [1:0]  kind_q;
	logic [15:0] code_q;
	logic        pass_o_q, last_q;
	logic        single_unreg_q, single_tap_q;
	logic [IdxW-1:0] list_id;
	logic        list_wait_q;
	logic        list_hold_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_q <= 16'd50;
			late_q  <= 16'd200;
			rule2_q <= 1'b1;
			use_q   <= 5'd0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_t'(paddr[3:2]))
				REG_EARLY: early_q <= pwdata[15:0];
				REG_LATE:  late_q  <= pwdata[15:0];
				REG_RULE2: rule2_q <= pwdata[0];
				REG_USE:   use_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_t'(paddr[3:2]))
			REG_EARLY: prdata = {16'd0, early_q};
			REG_LATE:  prdata = {16'd0, late_q};
			REG_RULE2: prdata = {31'd0, rule2_q};
			REG_USE:   prdata = {27'd0, use_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q  <= action_t'(action);
			pressed_q <= pressed;
			key_q     <= key_code;
			layer_q   <= active_layer;
			now_q     <= now_ms;
			slot_q    <= entry_index;
			hold_in_q <= hold_code;
		end
	end

	assign limit = (32'(use_q) > TableEntries) ? ScanW'(TableEntries) : ScanW'(use_q);

	// suspend list and table memories
	assign sus_we    = cmd.push_susp && (32'(scount_q) < SuspendDepth);
	assign sus_raddr = sidx_q[SusW-1:0];
	emtr_ram #(.Width(IdxW), .Depth(SuspendDepth)) u_sus (
		.clk(clk), .we(sus_we), .waddr(scount_q[SusW-1:0]), .wdata(hit_id_q),
		.raddr(sus_raddr), .rdata(sus_rd)
	);

	assign ent_we = cmd.write_entry && (32'(slot_q) < TableEntries);
	assign list_id = sus_rd;
	// hold the table address while a result waits on the output
	always_comb begin
		if (cmd.scan_step) begin
			ent_raddr = scan_q[IdxW-1:0];
		end else if (list_wait_q) begin
			ent_raddr = list_id;
		end else if (cmd.rd_single) begin
			ent_raddr = hit_id_q;
		end else begin
			ent_raddr = ent_addr_q;
		end
	end
	emtr_ram #(.Width(EntW), .Depth(TableEntries)) u_ent (
		.clk(clk), .we(ent_we), .waddr(slot_q[IdxW-1:0]),
		.wdata({layer_q, key_q, hold_in_q}), .raddr(ent_raddr), .rdata(ent_rd)
	);

	// suspend list read is two-step: id, then the entry it names
	always_ff @(posedge clk) begin
		ent_addr_q <= ent_raddr;
		if (list_wait_q) begin
			rd_addr_q <= list_id;
		end
	end

	logic [4:0]  ent_layer;
	logic [15:0] ent_tap, ent_hold;
	assign {ent_layer, ent_tap, ent_hold} = ent_rd;

	logic scan_wait_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_WAITING;
			dstamp_q   <= '0;
			tstamp_q   <= '0;
			scount_q   <= '0;
			hcount_q   <= '0;
			held_q     <= '0;
			scan_q     <= '0;
			sidx_q     <= '0;
			hit_q      <= 1'b0;
			hit_id_q   <= '0;
			pass_q     <= 1'b0;
			scan_wait_q <= 1'b0;
			list_wait_q <= 1'b0;
			single_unreg_q <= 1'b0;
			single_tap_q   <= 1'b0;
		end else begin
			scan_wait_q <= cmd.scan_step;
			list_wait_q <= cmd.list_step;
			if (cmd.scan_start) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				pass_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
			end
			if (scan_wait_q && ent_layer == layer_q && ent_tap == key_q) begin
				hit_q    <= 1'b1;
				hit_id_q <= IdxW'(scan_q - 1'b1);
			end
			if (cmd.set_pass) begin
				pass_q <= (action_q == ACT_KEY) &&
					!((mode_q == MODE_WAITING && pressed_q && hit_q) ||
					  (mode_q != MODE_WAITING && hit_q));
			end
			if (cmd.set_mode)   mode_q   <= cmd.new_mode;
			if (cmd.set_dstamp) dstamp_q <= now_q;
			if (cmd.set_tstamp) tstamp_q <= now_q;
			if (sus_we)         scount_q <= scount_q + 1'b1;
			if (cmd.list_start) sidx_q   <= '0;
			if (cmd.list_step)  sidx_q   <= sidx_q + 1'b1;
			if (cmd.set_held_cnt) hcount_q <= scount_q;
			if (cmd.emit_list && list_hold_q) held_q[rd_addr_q] <= 1'b1;
			if (cmd.clr_susp)   scount_q <= '0;
			if (cmd.unhold) begin
				held_q[hit_id_q] <= 1'b0;
				if (hcount_q != '0) hcount_q <= hcount_q - 1'b1;
			end
			if (cmd.rd_single) begin
				single_unreg_q <= cmd.single_unreg;
				single_tap_q   <= cmd.single_tap;
			end
		end
	end

	// hold-list flag tracked for emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_hold_q <= 1'b0;
		end else if (cmd.list_start) begin
			list_hold_q <= cmd.list_hold;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit_list || cmd.emit_single || cmd.emit_end) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_list) begin
			kind_q   <= KIND_REG;
			code_q   <= list_hold_q ? ent_hold : ent_tap;
			pass_o_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (cmd.emit_single) begin
			kind_q   <= single_unreg_q ? KIND_UNREG : KIND_REG;
			code_q   <= single_tap_q ? ent_tap : ent_hold;
			pass_o_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (cmd.emit_end) begin
			kind_q   <= KIND_END;
			code_q   <= '0;
			pass_o_q <= pass_q;
			last_q   <= 1'b1;
		end
	end

	logic [15:0] el_d, el_t;
	assign el_d = now_q - dstamp_q;
	assign el_t = now_q - tstamp_q;

	assign kind         = kind_q;
	assign code         = code_q;
	assign pass_through = pass_o_q;
	assign last         = last_q;
	assign out_valid    = ov_q;

	always_comb begin
		st              = '0;
		st.scan_done    = (scan_q >= limit) || hit_q;
		st.hit          = hit_q;
		st.list_done    = (sidx_q >= scount_q);
		st.out_busy     = ov_q && out_stall;
		st.mode         = mode_q;
		st.action       = action_q;
		st.pressed      = pressed_q;
		st.held_bit     = held_q[hit_id_q];
		st.held_cnt_le1 = (hcount_q <= CntW'(1));
		st.early_hit    = (el_d >= early_q);
		st.late_hit_d   = (el_d > late_q);
		st.late_hit_t   = (el_t > late_q);
		st.rule_two     = rule2_q;
	end

	a_scount_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scount_q) <= SuspendDepth)
		else $error("suspend count beyond depth");
	a_hcount_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hcount_q) <= SuspendDepth)
		else $error("held count beyond depth");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.emit_list, cmd.emit_single, cmd.emit_end}) <= 1)
		else $error("two result sources at once");
endmodule
`default_nettype wire

// ===== src/eager_mod_tap_resolver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake            | payload
// in       | in_valid / in_stall  | action pressed key_code active_layer now_ms
//          |                      | entry_index hold_code
// out      | out_valid / out_stall| kind code pass_through last
// config   | APB psel/penable     | paddr pwdata prdata
// Per entry, the table scan reads the table RAM, then compares; per id, the suspend
// list emission reads the list RAM, then the table RAM, then loads the output.
// Reset clears mode, stamps, counts and held marks; the table needs no clearing.
// A stalled output holds the controller; input is taken only between items.
module eager_mod_tap_resolver_core import emtr_pkg::*; #(
	parameter int TableEntries = TableEntriesDef,
	parameter int SuspendDepth = SuspendDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic        pressed,
	input  wire logic [15:0] key_code,
	input  wire logic [4:0]  active_layer,
	input  wire logic [15:0] now_ms,
	input  wire logic [3:0]  entry_index,
	input  wire logic [15:0] hold_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  kind,
	output logic      [15:0] code,
	output logic             pass_through,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	cmd_t  cmd;
	stat_t st;

	assign pready = 1'b1;

	emtr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.st(st), .cmd(cmd)
	);

	emtr_dp #(.TableEntries(TableEntries), .SuspendDepth(SuspendDepth)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.action(action), .pressed(pressed), .key_code(key_code),
		.active_layer(active_layer), .now_ms(now_ms), .entry_index(entry_index),
		.hold_code(hold_code), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.kind(kind), .code(code), .pass_through(pass_through), .last(last),
		.out_valid(out_valid), .out_stall(out_stall)
	);
endmodule
`default_nettype wire
